// ===== rtl/fitb_pkg.sv =====
package fitb_pkg;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Result status carried in m_tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_VERTEX_COUNT = 8'd0;
    localparam logic [7:0] CFG_BIG_M        = 8'd1;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDPOS,
        ST_SCAN,
        ST_INS_PREV,
        ST_INS_PV,
        ST_INS_T,
        ST_INS_A,
        ST_INS_B,
        ST_INS_C,
        ST_INS_D,
        ST_INS_E,
        ST_SH_R,
        ST_SH_W,
        ST_COMMIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/fitb_ram.sv =====
module fitb_ram #(
    parameter int DW    = 32,
    parameter int AW    = 12,
    parameter int DEPTH = 4096
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/fitb_alu.sv =====
module fitb_alu import fitb_pkg::*; #(
    parameter int W = 43
) (
    input  alu_op_t             op,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] res,
    output logic        [W-1:0] mag
);

    // add or subtract, then magnitude of the result
    always_comb begin
        case (op)
            ALU_ADD: res = a + b;
            ALU_SUB: res = a - b;
            default: res = a + b;
        endcase
        mag = res[W-1] ? (~$unsigned(res) + W'(1)) : $unsigned(res);
    end

endmodule

// ===== rtl/farthest_insertion_tour_build_unit.sv =====
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tuser: cmd; s_tdata: from, to, weight
// m_        out  m_tvalid/m_tready   m_tuser: status; m_tdata: vertex, pos, sum, len
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// Write, clear, first-add, full-add and out-of-range requests go straight to the result;
// a tour read first reads the tour memory. An add step on a tour of n vertices with V
// active vertices scans the free vertices against the tour (at most one edge-weight
// read per cycle), then runs the insertion search over all n positions, then shifts
// and writes for insertion position p, and then loads the result.
// Reset is synchronous and clears the tour; edge weights are not cleared.
// s_tready is low while a request is in work; a stalled result holds the block
// in its final state until m_tready.
module farthest_insertion_tour_build_unit import fitb_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // from_vertex[5:0], to_vertex[11:6], weight[43:12]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // vertex[5:0], position[11:6], tour_sum[51:12],
                                   // tour_length[58:52]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int GW  = (CW > 7) ? CW : 7;
    localparam int EAW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int OW  = ((WEIGHT_BITS > 40) ? WEIGHT_BITS : 40) + 3;
    localparam int KW  = (WEIGHT_BITS > 31) ? WEIGHT_BITS : 31;

    function automatic logic [EAW-1:0] edge_addr(input logic [VW-1:0] r,
                                                 input logic [VW-1:0] col);
        return EAW'(r) * EAW'(MAX_VERTICES) + EAW'(col);
    endfunction

    state_t state_reg, state_next;

    logic [6:0]              vcount_reg;
    logic [30:0]             big_m_reg;
    logic [MAX_VERTICES-1:0] in_tour_reg;
    logic [CW-1:0]           tour_count_reg;
    logic signed [39:0]      tour_total_reg;

    logic [CW-1:0] c_reg, i_reg, j_reg;
    logic          p1_valid_reg, p1_first_reg, p1_last_reg;
    logic          p2_valid_reg, p2_first_reg, p2_last_reg;
    logic [VW-1:0] p1_c_reg, p2_c_reg;
    logic [WEIGHT_BITS-1:0] run_min_reg;
    logic          cand_valid_reg;
    logic [KW-1:0] cand_score_reg;
    logic [VW-1:0] cand_c_reg;
    logic          have_reg;
    logic [KW-1:0] best_score_reg;
    logic [VW-1:0] best_reg, pv_reg, nx_reg;
    logic signed [OW-1:0] acc_reg, ab_reg, best_full_reg, best_ab_reg;
    logic [OW-1:0] best_obj_reg;
    logic [CW-1:0] best_pos_reg;
    logic [VW-1:0] res_vertex_reg;
    logic [5:0]    res_pos_reg;
    status_t       res_status_reg;
    logic          m_tvalid_reg;
    logic [63:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    // request fields
    cmd_t        in_cmd;
    logic [5:0]  in_fv, in_tv;
    logic [31:0] in_w;
    assign in_cmd = cmd_t'(s_tuser);
    assign in_fv  = s_tdata[5:0];
    assign in_tv  = s_tdata[11:6];
    assign in_w   = s_tdata[43:12];

    logic accept;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // active vertex count, clamped to 1..MAX_VERTICES
    logic [GW-1:0] vc_wide;
    logic [CW-1:0] vc;
    always_comb begin
        vc_wide = GW'(vcount_reg);
        if (vc_wide == GW'(0)) begin
            vc_wide = GW'(1);
        end else if (vc_wide > GW'(MAX_VERTICES)) begin
            vc_wide = GW'(MAX_VERTICES);
        end
        vc = CW'(vc_wide);
    end

    logic full, in_range_wr, in_range_rd, last_i, scan_live, c_free, scan_issue, scan_empty;
    assign full        = (tour_count_reg >= vc);
    assign in_range_wr = (GW'(in_fv) < GW'(MAX_VERTICES)) && (GW'(in_tv) < GW'(MAX_VERTICES));
    assign in_range_rd = (GW'(in_tv) < GW'(tour_count_reg));
    assign last_i      = (i_reg == tour_count_reg - CW'(1));
    assign scan_live   = (c_reg < vc);
    assign c_free      = !in_tour_reg[c_reg[VW-1:0]];
    assign scan_issue  = (state_reg == ST_SCAN) && scan_live && c_free;
    assign scan_empty  = !scan_live && !p1_valid_reg && !p2_valid_reg && !cand_valid_reg;

    // memories and shared adder
    logic                   edge_wr_en, edge_rd_en;
    logic [EAW-1:0]         edge_wr_addr, edge_rd_addr;
    logic [WEIGHT_BITS-1:0] edge_wr_data, edge_rd_data;
    logic                   tour_wr_en, tour_rd_en;
    logic [VW-1:0]          tour_wr_addr, tour_rd_addr, tour_wr_data, tour_rd_data;
    alu_op_t                alu_op;
    logic signed [OW-1:0]   alu_a, alu_b, alu_res, edge_ext, total_ext;
    logic [OW-1:0]          alu_mag;

    assign edge_ext  = OW'($signed(edge_rd_data));
    assign total_ext = OW'(tour_total_reg);

    fitb_ram #(.DW(WEIGHT_BITS), .AW(EAW), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_edge (
        .aclk    (aclk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_wr_addr),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    fitb_ram #(.DW(VW), .AW(VW), .DEPTH(MAX_VERTICES)) u_tour (
        .aclk    (aclk),
        .wr_en   (tour_wr_en),
        .wr_addr (tour_wr_addr),
        .wr_data (tour_wr_data),
        .rd_en   (tour_rd_en),
        .rd_addr (tour_rd_addr),
        .rd_data (tour_rd_data)
    );

    fitb_alu #(.W(OW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .mag (alu_mag)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_cmd)
                        CMD_ADD: begin
                            if (full || tour_count_reg == CW'(0)) state_next = ST_DONE;
                            else state_next = ST_SCAN;
                        end
                        CMD_READ: state_next = in_range_rd ? ST_RDPOS : ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_RDPOS:    state_next = ST_DONE;
            ST_SCAN:     if (scan_empty) state_next = ST_INS_PREV;
            ST_INS_PREV: state_next = ST_INS_PV;
            ST_INS_PV:   state_next = ST_INS_T;
            ST_INS_T:    state_next = ST_INS_A;
            ST_INS_A:    state_next = ST_INS_B;
            ST_INS_B:    state_next = ST_INS_C;
            ST_INS_C:    state_next = ST_INS_D;
            ST_INS_D:    state_next = ST_INS_E;
            ST_INS_E:    state_next = last_i ? ST_SH_R : ST_INS_T;
            ST_SH_R:     state_next = (j_reg > best_pos_reg) ? ST_SH_W : ST_COMMIT;
            ST_SH_W:     state_next = ST_SH_R;
            ST_COMMIT:   state_next = ST_DONE;
            ST_DONE:     if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory and adder controls
    always_comb begin
        edge_wr_en   = 1'b0;
        edge_wr_addr = edge_addr(VW'(in_fv), VW'(in_tv));
        edge_wr_data = WEIGHT_BITS'($signed(in_w));
        edge_rd_en   = 1'b0;
        edge_rd_addr = edge_addr(pv_reg, best_reg);
        tour_wr_en   = 1'b0;
        tour_wr_addr = j_reg[VW-1:0];
        tour_wr_data = tour_rd_data;
        tour_rd_en   = 1'b0;
        tour_rd_addr = i_reg[VW-1:0];
        alu_op       = ALU_ADD;
        alu_a        = acc_reg;
        alu_b        = edge_ext;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_cmd)
                        CMD_WRITE: edge_wr_en = in_range_wr;
                        CMD_ADD: begin
                            tour_wr_en   = !full && (tour_count_reg == CW'(0));
                            tour_wr_addr = '0;
                            tour_wr_data = '0;
                        end
                        CMD_READ: begin
                            tour_rd_en   = in_range_rd;
                            tour_rd_addr = VW'(in_tv);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                tour_rd_en   = scan_issue;
                edge_rd_en   = p1_valid_reg;
                edge_rd_addr = edge_addr(p1_c_reg, tour_rd_data);
                alu_a        = '0;
            end
            ST_INS_PREV: begin
                tour_rd_en   = 1'b1;
                tour_rd_addr = VW'(tour_count_reg - CW'(1));
            end
            ST_INS_T: tour_rd_en = 1'b1;
            ST_INS_A: edge_rd_en = 1'b1;
            ST_INS_B: begin
                edge_rd_en   = 1'b1;
                edge_rd_addr = edge_addr(best_reg, nx_reg);
                alu_a        = total_ext;
            end
            ST_INS_C: begin
                edge_rd_en   = 1'b1;
                edge_rd_addr = edge_addr(pv_reg, nx_reg);
            end
            ST_INS_D: alu_op = ALU_SUB;
            ST_INS_E: alu_b = '0;
            ST_SH_R: begin
                tour_rd_en   = (j_reg > best_pos_reg);
                tour_rd_addr = VW'(j_reg - CW'(1));
            end
            ST_SH_W: tour_wr_en = 1'b1;
            ST_COMMIT: begin
                tour_wr_en   = 1'b1;
                tour_wr_addr = best_pos_reg[VW-1:0];
                tour_wr_data = best_reg;
            end
            default: ;
        endcase
    end

    // running minimum of the candidate's distances to the tour
    logic [WEIGHT_BITS-1:0] edge_mag, scan_min;
    assign edge_mag = alu_mag[WEIGHT_BITS-1:0];
    assign scan_min = (p2_first_reg || edge_mag < run_min_reg) ? edge_mag : run_min_reg;

    logic better_cand;
    assign better_cand = !have_reg ||
                         (cand_score_reg != KW'(big_m_reg) && cand_score_reg > best_score_reg);

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            vcount_reg     <= 7'd64;
            big_m_reg      <= 31'h7FFF_FFFF;
            in_tour_reg    <= '0;
            tour_count_reg <= '0;
            tour_total_reg <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            cand_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid) begin
                if (cfg_index == CFG_VERTEX_COUNT) vcount_reg <= cfg_data[6:0];
                else if (cfg_index == CFG_BIG_M) big_m_reg <= cfg_data[30:0];
            end

            // scan pipeline: tour read, edge read, min, best compare
            p1_valid_reg   <= scan_issue;
            p1_first_reg   <= (i_reg == CW'(0));
            p1_last_reg    <= last_i;
            p1_c_reg       <= c_reg[VW-1:0];
            p2_valid_reg   <= p1_valid_reg;
            p2_first_reg   <= p1_first_reg;
            p2_last_reg    <= p1_last_reg;
            p2_c_reg       <= p1_c_reg;
            cand_valid_reg <= p2_valid_reg && p2_last_reg;
            if (p2_valid_reg) begin
                run_min_reg    <= scan_min;
                cand_score_reg <= KW'(scan_min);
                cand_c_reg     <= p2_c_reg;
            end
            if (cand_valid_reg && better_cand) begin
                best_reg       <= cand_c_reg;
                best_score_reg <= cand_score_reg;
                have_reg       <= 1'b1;
            end

            // result valid: a new result replaces one taken this cycle
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_vertex_reg <= '0;
                        res_pos_reg    <= '0;
                        res_status_reg <= STAT_OK;
                        c_reg          <= '0;
                        i_reg          <= '0;
                        have_reg       <= 1'b0;
                        case (in_cmd)
                            CMD_CLEAR: begin
                                in_tour_reg    <= '0;
                                tour_count_reg <= '0;
                                tour_total_reg <= '0;
                            end
                            CMD_ADD: begin
                                if (full) begin
                                    res_status_reg <= STAT_FULL;
                                end else if (tour_count_reg == CW'(0)) begin
                                    in_tour_reg[0] <= 1'b1;
                                    tour_count_reg <= CW'(1);
                                    tour_total_reg <= '0;
                                end
                            end
                            CMD_READ: begin
                                if (in_range_rd) res_pos_reg <= in_tv;
                                else res_status_reg <= STAT_RANGE;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RDPOS: res_vertex_reg <= tour_rd_data;
                ST_SCAN: begin
                    if (scan_live) begin
                        if (!c_free) begin
                            c_reg <= c_reg + CW'(1);
                        end else if (last_i) begin
                            i_reg <= '0;
                            c_reg <= c_reg + CW'(1);
                        end else begin
                            i_reg <= i_reg + CW'(1);
                        end
                    end
                end
                ST_INS_PREV: i_reg <= '0;
                ST_INS_PV:   pv_reg <= tour_rd_data;
                ST_INS_A:    nx_reg <= tour_rd_data;
                ST_INS_B:    acc_reg <= alu_res;
                ST_INS_C: begin
                    acc_reg <= alu_res;
                    ab_reg  <= alu_res;
                end
                ST_INS_D:    acc_reg <= alu_res;
                ST_INS_E: begin
                    if (i_reg == CW'(0) || alu_mag < best_obj_reg) begin
                        best_obj_reg  <= alu_mag;
                        best_pos_reg  <= i_reg;
                        best_full_reg <= acc_reg;
                        best_ab_reg   <= ab_reg;
                    end
                    pv_reg <= nx_reg;
                    i_reg  <= i_reg + CW'(1);
                    j_reg  <= tour_count_reg;
                end
                ST_SH_W: j_reg <= j_reg - CW'(1);
                ST_COMMIT: begin
                    in_tour_reg[best_reg] <= 1'b1;
                    tour_count_reg        <= tour_count_reg + CW'(1);
                    // a one-vertex tour closes with both new edges only
                    if (tour_count_reg == CW'(1)) tour_total_reg <= best_ab_reg[39:0];
                    else tour_total_reg <= best_full_reg[39:0];
                    res_vertex_reg <= best_reg;
                    res_pos_reg    <= 6'(best_pos_reg);
                    res_status_reg <= STAT_OK;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {5'd0, 7'(tour_count_reg), tour_total_reg,
                                         res_pos_reg, 6'(res_vertex_reg)};
                        m_tuser_reg  <= res_status_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        tour_count_reg <= CW'(MAX_VERTICES))
        else $error("tour count above vertex capacity");

    a_commit_new: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMMIT |-> !in_tour_reg[best_reg])
        else $error("inserted vertex already in tour");

    a_commit_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMMIT |=> tour_count_reg == $past(tour_count_reg) + CW'(1))
        else $error("tour did not grow by one on insert");

    a_pipe_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> state_reg == ST_SCAN)
        else $error("scan pipeline busy outside scan");

endmodule
